### design/ffa_pkg.sv
// Package of the first-fit allocator core: sizes, command and status codes,
// datapath operation codes and the control/status structs.
// Depends on nothing; every other design file imports it.
`default_nettype none

package ffa_pkg;

    localparam int MAX_EXTENTS  = 16;
    localparam int MAX_LIVE     = 32;
    localparam int HEADER_BYTES = 16;
    localparam int ADDR_BITS    = 32;

    localparam int EXT_IW = $clog2(MAX_EXTENTS);
    localparam int EXT_CW = $clog2(MAX_EXTENTS + 1);
    localparam int REC_IW = $clog2(MAX_LIVE);
    localparam int CNT_W  = ((EXT_IW > REC_IW) ? EXT_IW : REC_IW) + 1;
    localparam int LIM_W  = (ADDR_BITS >= 32) ? 32 : ADDR_BITS;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_INIT    = 2'd2;

    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_SIZE = 2'd1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_BAD     = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_SLOT,
        OP_SCAN_NEXT,
        OP_SPLIT,
        OP_TAKE_ALL,
        OP_SHIFT_DN,
        OP_SHRINK,
        OP_REC_STEP,
        OP_REC_HIT,
        OP_FINDP_STEP,
        OP_MERGE_BOTH,
        OP_MERGE_PREV,
        OP_MERGE_NEXT,
        OP_UP_INIT,
        OP_SHIFT_UP,
        OP_INSERT,
        OP_FIN_ALLOC,
        OP_FIN_REL,
        OP_FIN_PLAIN
    } dp_op_t;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_NEXT,
        RD_PREV
    } rd_sel_t;

    typedef struct packed {
        dp_op_t     op;
        rd_sel_t    rd_sel;
        logic [2:0] fin_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       bad_req;
        logic       rel_zero;
        logic       slot_full;
        logic       scan_end;
        logic       scan_hit;
        logic       scan_small;
        logic       dn_more;
        logic       rec_end;
        logic       rec_hit;
        logic       p_stop;
        logic       join_prev;
        logic       join_next;
        logic       ext_full;
        logic       up_more;
    } dp_status_t;

endpackage

`default_nettype wire

### design/ffa_ctrl.sv
// Sequencer of the allocator core: walks each command through its steps.
// Depends on ffa_pkg; drives ffa_datapath through ctl_cmd_t.
`default_nettype none

module ffa_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire ffa_pkg::dp_status_t stat,
    output ffa_pkg::ctl_cmd_t   cmd
);
    import ffa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT_DN,
        S_LOOKUP,
        S_FINDP,
        S_SHIFT_UP,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.rd_sel     = RD_CUR;
        cmd.fin_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (stat.command)
                    CMD_ALLOC:
                    begin
                        if (stat.bad_req)
                        begin
                            cmd.op         = OP_FIN_PLAIN;
                            cmd.fin_status = ST_BAD;
                        end
                        else if (stat.slot_full)
                        begin
                            cmd.op         = OP_FIN_PLAIN;
                            cmd.fin_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.op     = OP_SLOT;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (stat.rel_zero)
                        begin
                            cmd.op = OP_FIN_PLAIN;
                        end
                        else
                        begin
                            state_next = S_LOOKUP;
                        end
                    end
                    CMD_INIT:
                    begin
                        cmd.op = OP_INIT;
                    end
                    default:
                    begin
                        cmd.op         = OP_FIN_PLAIN;
                        cmd.fin_status = ST_BAD;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.op         = OP_FIN_PLAIN;
                    cmd.fin_status = ST_NOFIT;
                    state_next     = S_IDLE;
                end
                else if (stat.scan_hit && stat.scan_small)
                begin
                    cmd.op     = OP_TAKE_ALL;
                    state_next = S_SHIFT_DN;
                end
                else if (stat.scan_hit)
                begin
                    cmd.op     = OP_SPLIT;
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.op = OP_SCAN_NEXT;
                end
            end
            S_SHIFT_DN:
            begin
                cmd.rd_sel = RD_NEXT;
                if (stat.dn_more)
                begin
                    cmd.op = OP_SHIFT_DN;
                end
                else
                begin
                    cmd.op     = OP_SHRINK;
                    state_next = S_COMMIT;
                end
            end
            S_LOOKUP:
            begin
                if (stat.rec_end)
                begin
                    cmd.op         = OP_FIN_PLAIN;
                    cmd.fin_status = ST_UNKNOWN;
                    state_next     = S_IDLE;
                end
                else if (stat.rec_hit)
                begin
                    cmd.op     = OP_REC_HIT;
                    state_next = S_FINDP;
                end
                else
                begin
                    cmd.op = OP_REC_STEP;
                end
            end
            S_FINDP:
            begin
                if (!stat.p_stop)
                begin
                    cmd.op = OP_FINDP_STEP;
                end
                else if (stat.join_prev && stat.join_next)
                begin
                    cmd.op     = OP_MERGE_BOTH;
                    state_next = S_SHIFT_DN;
                end
                else if (stat.join_prev)
                begin
                    cmd.op     = OP_MERGE_PREV;
                    state_next = S_COMMIT;
                end
                else if (stat.join_next)
                begin
                    cmd.op     = OP_MERGE_NEXT;
                    state_next = S_COMMIT;
                end
                else if (stat.ext_full)
                begin
                    cmd.op         = OP_FIN_PLAIN;
                    cmd.fin_status = ST_FULL;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_UP_INIT;
                    state_next = S_SHIFT_UP;
                end
            end
            S_SHIFT_UP:
            begin
                cmd.rd_sel = RD_PREV;
                if (stat.up_more)
                begin
                    cmd.op = OP_SHIFT_UP;
                end
                else
                begin
                    cmd.op     = OP_INSERT;
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.op     = (stat.command == CMD_ALLOC) ? OP_FIN_ALLOC : OP_FIN_REL;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

### design/ffa_datapath.sv
// Datapath of the allocator core: extent table, allocation records, usage
// total, configuration registers and result registers. Depends on ffa_pkg.
`default_nettype none

module ffa_datapath (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire ffa_pkg::ctl_cmd_t cmd,
    output ffa_pkg::dp_status_t stat,
    input  wire  [1:0]          command,
    input  wire  [31:0]         request_bytes,
    input  wire  [7:0]          align_bytes,
    input  wire  [31:0]         release_address,
    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_index,
    input  wire  [31:0]         cfg_data,
    output logic                done,
    output logic [2:0]          status,
    output logic [31:0]         granted_address,
    output logic [31:0]         granted_bytes,
    output logic [31:0]         bytes_in_use
);
    import ffa_pkg::*;

    logic [31:0] base_reg, size_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] req_reg, rel_reg;
    logic [7:0]  align_reg;

    logic [31:0] ext_start_reg [MAX_EXTENTS];
    logic [31:0] ext_len_reg   [MAX_EXTENTS];
    logic [EXT_CW-1:0] ext_count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [EXT_CW-1:0] p_reg;
    logic [REC_IW-1:0] slot_reg, rec_idx_reg;

    logic [31:0] rec_addr_reg  [MAX_LIVE];
    logic [31:0] rec_start_reg [MAX_LIVE];
    logic [31:0] rec_bytes_reg [MAX_LIVE];
    logic [MAX_LIVE-1:0] rec_valid_reg;

    logic [31:0] used_reg, aligned_reg, total_reg;
    logic [31:0] blk_start_reg, blk_bytes_reg, prev_len_reg;
    logic [32:0] blk_end_reg, prev_end_reg;
    logic        has_prev_reg;

    logic        done_reg;
    logic [2:0]  status_reg;
    logic [31:0] gaddr_reg, gbytes_reg;

    logic [EXT_IW-1:0] rd_ext, cur_ext, prv_ext;
    logic [REC_IW-1:0] cur_rec;
    logic [31:0] rs, rl;
    logic [32:0] aligned33, adj33;
    logic [33:0] total34;
    logic [31:0] rest;
    logic        in_table, fits, too_small;
    logic [REC_IW-1:0] slot_free;
    logic        slot_found;
    logic [32:0] lim33, room33, len33;
    logic [31:0] init_len;
    logic        fin_op;

    logic              ext_we_s, ext_we_l;
    logic [EXT_IW-1:0] ext_wa;
    logic [31:0]       ext_ws, ext_wl;

    assign cur_ext = idx_reg[EXT_IW-1:0];
    assign prv_ext = cur_ext - EXT_IW'(1);
    assign cur_rec = idx_reg[REC_IW-1:0];

    always_comb
    begin
        case (cmd.rd_sel)
            RD_NEXT: rd_ext = cur_ext + EXT_IW'(1);
            RD_PREV: rd_ext = prv_ext;
            default: rd_ext = cur_ext;
        endcase
    end

    assign rs = ext_start_reg[rd_ext];
    assign rl = ext_len_reg[rd_ext];

    // Header room first, then round up to the alignment.
    assign aligned33 = (33'(rs) + 33'(HEADER_BYTES) + 33'(align_reg) - 33'd1)
                       & ~(33'(align_reg) - 33'd1);
    assign adj33     = aligned33 - 33'(rs);
    assign total34   = 34'(req_reg) + 34'(adj33);
    assign fits      = (total34 <= 34'(rl));
    assign rest      = rl - total34[31:0];
    assign too_small = (rest == 32'd0) || (rest < 32'(HEADER_BYTES));
    assign in_table  = (idx_reg < CNT_W'(ext_count_reg));

    always_comb
    begin
        slot_free  = '0;
        slot_found = 1'b0;
        for (int i = 0; i < MAX_LIVE; i++)
        begin
            if (!slot_found && !rec_valid_reg[i])
            begin
                slot_free  = REC_IW'(i);
                slot_found = 1'b1;
            end
        end
    end

    // Region clipped to the address space.
    assign lim33    = 33'd1 << LIM_W;
    assign room33   = lim33 - 33'(base_reg);
    assign len33    = (33'(base_reg) >= lim33) ? 33'd0 :
                      ((33'(size_reg) > room33) ? room33 : 33'(size_reg));
    assign init_len = len33[31:0];

    always_comb
    begin
        stat.command    = cmd_reg;
        stat.bad_req    = (req_reg == 32'd0) || (align_reg == 8'd0) ||
                          ((align_reg & (align_reg - 8'd1)) != 8'd0);
        stat.rel_zero   = (rel_reg == 32'd0);
        stat.slot_full  = &rec_valid_reg;
        stat.scan_end   = !in_table;
        stat.scan_hit   = fits;
        stat.scan_small = too_small;
        stat.dn_more    = ((idx_reg + CNT_W'(1)) < CNT_W'(ext_count_reg));
        stat.rec_end    = (idx_reg == CNT_W'(MAX_LIVE));
        stat.rec_hit    = (idx_reg != CNT_W'(MAX_LIVE)) && rec_valid_reg[cur_rec] &&
                          (rec_addr_reg[cur_rec] == rel_reg);
        stat.p_stop     = !in_table || (rs > blk_start_reg);
        stat.join_prev  = has_prev_reg && (prev_end_reg == 33'(blk_start_reg));
        stat.join_next  = in_table && (33'(rs) == blk_end_reg);
        stat.ext_full   = (ext_count_reg == EXT_CW'(MAX_EXTENTS));
        stat.up_more    = (idx_reg > CNT_W'(p_reg));
    end

    // Single write port of the extent table.
    always_comb
    begin
        ext_we_s = 1'b0;
        ext_we_l = 1'b0;
        ext_wa   = cur_ext;
        ext_ws   = rs;
        ext_wl   = rl;
        case (cmd.op)
            OP_INIT:
            begin
                ext_we_s = 1'b1;
                ext_we_l = 1'b1;
                ext_wa   = '0;
                ext_ws   = base_reg;
                ext_wl   = init_len;
            end
            OP_SPLIT:
            begin
                ext_we_s = 1'b1;
                ext_we_l = 1'b1;
                ext_ws   = rs + total34[31:0];
                ext_wl   = rest;
            end
            OP_SHIFT_DN, OP_SHIFT_UP:
            begin
                ext_we_s = 1'b1;
                ext_we_l = 1'b1;
            end
            OP_MERGE_BOTH:
            begin
                ext_we_l = 1'b1;
                ext_wa   = prv_ext;
                ext_wl   = prev_len_reg + blk_bytes_reg + rl;
            end
            OP_MERGE_PREV:
            begin
                ext_we_l = 1'b1;
                ext_wa   = prv_ext;
                ext_wl   = prev_len_reg + blk_bytes_reg;
            end
            OP_MERGE_NEXT:
            begin
                ext_we_s = 1'b1;
                ext_we_l = 1'b1;
                ext_ws   = blk_start_reg;
                ext_wl   = rl + blk_bytes_reg;
            end
            OP_INSERT:
            begin
                ext_we_s = 1'b1;
                ext_we_l = 1'b1;
                ext_wa   = p_reg[EXT_IW-1:0];
                ext_ws   = blk_start_reg;
                ext_wl   = blk_bytes_reg;
            end
            default:
            begin
                ext_we_s = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ext_we_s)
        begin
            ext_start_reg[ext_wa] <= ext_ws;
        end
        if (ext_we_l)
        begin
            ext_len_reg[ext_wa] <= ext_wl;
        end
        if (cmd.op == OP_FIN_ALLOC)
        begin
            rec_addr_reg[slot_reg]  <= aligned_reg;
            rec_start_reg[slot_reg] <= blk_start_reg;
            rec_bytes_reg[slot_reg] <= total_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                cmd_reg   <= command;
                req_reg   <= request_bytes;
                align_reg <= align_bytes;
                rel_reg   <= release_address;
            end
            OP_SLOT:
            begin
                slot_reg <= slot_free;
            end
            OP_SPLIT:
            begin
                aligned_reg   <= aligned33[31:0];
                total_reg     <= total34[31:0];
                blk_start_reg <= rs;
            end
            OP_TAKE_ALL:
            begin
                aligned_reg   <= aligned33[31:0];
                total_reg     <= rl;
                blk_start_reg <= rs;
            end
            OP_REC_HIT:
            begin
                rec_idx_reg   <= cur_rec;
                blk_start_reg <= rec_start_reg[cur_rec];
                blk_bytes_reg <= rec_bytes_reg[cur_rec];
                blk_end_reg   <= 33'(rec_start_reg[cur_rec]) + 33'(rec_bytes_reg[cur_rec]);
            end
            OP_FINDP_STEP:
            begin
                prev_end_reg <= 33'(rs) + 33'(rl);
                prev_len_reg <= rl;
            end
            OP_UP_INIT:
            begin
                p_reg <= idx_reg[EXT_CW-1:0];
            end
            OP_INIT, OP_FIN_PLAIN:
            begin
                status_reg <= cmd.fin_status;
                gaddr_reg  <= 32'd0;
                gbytes_reg <= 32'd0;
            end
            OP_FIN_ALLOC:
            begin
                status_reg <= ST_OK;
                gaddr_reg  <= aligned_reg;
                gbytes_reg <= total_reg;
            end
            OP_FIN_REL:
            begin
                status_reg <= ST_OK;
                gaddr_reg  <= 32'd0;
                gbytes_reg <= blk_bytes_reg;
            end
            default:
            begin
                status_reg <= status_reg;
            end
        endcase
    end

    // A result beat follows every step that finishes a command.
    assign fin_op = (cmd.op == OP_INIT) || (cmd.op == OP_FIN_ALLOC) ||
                    (cmd.op == OP_FIN_REL) || (cmd.op == OP_FIN_PLAIN);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= 32'd0;
            size_reg      <= 32'd65536;
            idx_reg       <= '0;
            ext_count_reg <= '0;
            rec_valid_reg <= '0;
            used_reg      <= 32'd0;
            has_prev_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= fin_op;
            if (cfg_we && (cfg_index == CFG_BASE))
            begin
                base_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_SIZE))
            begin
                size_reg <= cfg_data;
            end
            case (cmd.op)
                OP_LOAD, OP_SLOT:
                begin
                    idx_reg <= '0;
                end
                OP_INIT:
                begin
                    ext_count_reg <= (init_len == 32'd0) ? EXT_CW'(0) : EXT_CW'(1);
                    rec_valid_reg <= '0;
                    used_reg      <= 32'd0;
                end
                OP_SCAN_NEXT, OP_SHIFT_DN, OP_REC_STEP:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                OP_SHRINK:
                begin
                    ext_count_reg <= ext_count_reg - EXT_CW'(1);
                end
                OP_REC_HIT:
                begin
                    idx_reg      <= '0;
                    has_prev_reg <= 1'b0;
                end
                OP_FINDP_STEP:
                begin
                    idx_reg      <= idx_reg + CNT_W'(1);
                    has_prev_reg <= 1'b1;
                end
                OP_UP_INIT:
                begin
                    idx_reg <= CNT_W'(ext_count_reg);
                end
                OP_SHIFT_UP:
                begin
                    idx_reg <= idx_reg - CNT_W'(1);
                end
                OP_INSERT:
                begin
                    ext_count_reg <= ext_count_reg + EXT_CW'(1);
                end
                OP_FIN_ALLOC:
                begin
                    rec_valid_reg[slot_reg] <= 1'b1;
                    used_reg                <= used_reg + total_reg;
                end
                OP_FIN_REL:
                begin
                    rec_valid_reg[rec_idx_reg] <= 1'b0;
                    used_reg <= (used_reg >= blk_bytes_reg) ? used_reg - blk_bytes_reg
                                                            : 32'd0;
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_address = gaddr_reg;
    assign granted_bytes   = gbytes_reg;
    assign bytes_in_use    = used_reg;

endmodule

`default_nettype wire

### design/first_fit_free_list_allocator_core.sv
// Top level of the first-fit free-list allocator with coalescing.
// Depends on ffa_pkg, ffa_ctrl and ffa_datapath.
//
//   Channel   Handshake            Beat contents
//   -------   ------------------   ---------------------------------------------
//   command   start / busy         command, request_bytes, align_bytes,
//                                  release_address
//   result    done (one cycle)     status, granted_address, granted_bytes,
//                                  bytes_in_use
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A command beat is taken when start is high and busy is low. Initialize and
// rejected commands finish at the decode step. An allocate scans the extents
// in order and, when an extent is used up, moves the later entries down; a
// release searches the records, walks the extents to the freed block's place
// and moves the later entries up when it adds an extent, or down when it
// joins two. The extent and record tables are stepped one entry a cycle
// through a single read port. The result beat shows for exactly one cycle,
// in the cycle after the last step; the receiver cannot stall it. A new
// command may be started in that cycle. Reset clears the extent count, the
// record valid bits and the usage total; the tables themselves need no
// clearing. Configuration is accepted whenever busy is low and takes effect
// at the next initialize.
`default_nettype none

module first_fit_free_list_allocator_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  command,
    input  wire  [31:0] request_bytes,
    input  wire  [7:0]  align_bytes,
    input  wire  [31:0] release_address,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] granted_address,
    output logic [31:0] granted_bytes,
    output logic [31:0] bytes_in_use
);
    import ffa_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t stat;

    // Registers only change while idle, so writes are taken whenever busy is low.
    assign cfg_ready = !busy;

    ffa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ffa_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .command         (command),
        .request_bytes   (request_bytes),
        .align_bytes     (align_bytes),
        .release_address (release_address),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .status          (status),
        .granted_address (granted_address),
        .granted_bytes   (granted_bytes),
        .bytes_in_use    (bytes_in_use)
    );

endmodule

`default_nettype wire

### design/ffa_checker.sv
// Port-level checks of the allocator core, bound to the top level.
// Depends on ffa_pkg for the status codes and on the top level's ports.
`default_nettype none

module ffa_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire        done,
    input wire [2:0]  status,
    input wire [31:0] granted_address,
    input wire [31:0] granted_bytes
);
    import ffa_pkg::*;

    // An accepted command makes the core busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command beat accepted but core not busy");

    // A result only follows a cycle of work.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without preceding work");

    // Status stays within its defined codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_NOFIT || status == ST_FULL ||
                  status == ST_UNKNOWN || status == ST_BAD))
        else $error("undefined status code");

    // Failed commands hand nothing out.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (granted_address == 32'd0 && granted_bytes == 32'd0))
        else $error("failed command reports an address or size");

endmodule

bind first_fit_free_list_allocator_core ffa_checker u_ffa_checker (.*);

`default_nettype wire
